// ----- src/mqct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Memory quota container table package
// Shared widths, command codes, table record types and helper functions.
// ----------------------------------------------------------------------------
package mqct_pkg;

  // Table geometry and field widths.
  localparam int NUM_ENTRIES = 64;
  localparam int MAX_KIDS    = 3;
  localparam int PAGE_BITS   = 20;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int ID_W        = 6;
  localparam int KID_W       = 2;
  localparam int NEW_W       = 7;
  localparam int SLOT_W      = 9;
  localparam int CMD_W       = 2;

  // Stream data widths.
  localparam int IN_W      = CMD_W + ID_W + 2 * PAGE_BITS;
  localparam int RES_W     = ID_W + KID_W + 3 * PAGE_BITS + 1 + NEW_W;
  localparam int OUT_BYTES = (RES_W + 7) / 8;
  localparam int OUT_W     = OUT_BYTES * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPLIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

  // Usage and child count of one entry.
  typedef struct packed {
    logic [KID_W-1:0]     children;
    logic [PAGE_BITS-1:0] usage;
  } uc_rec_t;

  // Parent and quota of one entry.
  typedef struct packed {
    logic [ID_W-1:0]      parent;
    logic [PAGE_BITS-1:0] quota;
  } qp_rec_t;

  // Table write request from the execute logic.
  typedef struct packed {
    logic             uc_we;
    logic [IDX_W-1:0] uc_addr;
    uc_rec_t          uc;
    logic             qp_we;
    logic [IDX_W-1:0] qp_addr;
    qp_rec_t          qp;
  } tbl_wr_t;

  // Table contents of the addressed entry.
  typedef struct packed {
    uc_rec_t uc;
    qp_rec_t qp;
  } tbl_rd_t;

  // One result, last field in the lowest bits.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page_out;
    logic [NEW_W-1:0]     new_child;
    logic                 may_consume;
    logic [PAGE_BITS-1:0] usage_now;
    logic [PAGE_BITS-1:0] quota_now;
    logic [KID_W-1:0]     child_count;
    logic [ID_W-1:0]      parent_id;
  } res_t;

  // Unsigned add that saturates at the largest page count.
  function automatic logic [PAGE_BITS-1:0] add_sat(input logic [PAGE_BITS-1:0] a,
                                                   input logic [PAGE_BITS-1:0] b);
    logic [PAGE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PAGE_BITS] ? {PAGE_BITS{1'b1}} : s[PAGE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/mqct_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Container table storage
// Two memories with registered reads and write bypass, plus per-entry valid
// bits so unwritten entries read zero and new children have no usage or kids.
// ----------------------------------------------------------------------------
module mqct_store import mqct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic [IDX_W-1:0] st_addr,
  input  wire tbl_wr_t          wr,
  output tbl_rd_t               rd
);

  uc_rec_t uc_mem [NUM_ENTRIES];
  qp_rec_t qp_mem [NUM_ENTRIES];

  uc_rec_t uc_q;
  qp_rec_t qp_q;

  // live: usage and child count hold written data; clear reads zero.
  logic [NUM_ENTRIES-1:0] live;
  // qp_valid: parent and quota were written by a split.
  logic [NUM_ENTRIES-1:0] qp_valid;

  // Memory writes.
  always_ff @(posedge clk) begin
    if (wr.uc_we) begin
      uc_mem[wr.uc_addr] <= wr.uc;
    end
    if (wr.qp_we) begin
      qp_mem[wr.qp_addr] <= wr.qp;
    end
  end

  // Registered reads; a write at the same edge is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.uc_we && (wr.uc_addr == rd_addr)) begin
        uc_q <= wr.uc;
      end else begin
        uc_q <= uc_mem[rd_addr];
      end
      if (wr.qp_we && (wr.qp_addr == rd_addr)) begin
        qp_q <= wr.qp;
      end else begin
        qp_q <= qp_mem[rd_addr];
      end
    end
  end

  // Valid bits. A new child starts with zero usage and no children.
  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      qp_valid <= '0;
    end else begin
      if (wr.uc_we) begin
        live[wr.uc_addr] <= 1'b1;
      end
      if (wr.qp_we) begin
        live[wr.qp_addr]     <= 1'b0;
        qp_valid[wr.qp_addr] <= 1'b1;
      end
    end
  end

  // Entries that are not valid read as their reset value.
  always_comb begin
    rd.uc = live[st_addr]     ? uc_q : '0;
    rd.qp = qp_valid[st_addr] ? qp_q : '0;
  end

endmodule
`default_nettype wire

// ----- src/mqct_exec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Container command execute logic
// Applies one command to the addressed entry and forms the result and the
// table write requests.
// ----------------------------------------------------------------------------
module mqct_exec import mqct_pkg::*; (
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [ID_W-1:0]      id,
  input  wire logic [PAGE_BITS-1:0] amount,
  input  wire logic [PAGE_BITS-1:0] page,
  input  wire logic [PAGE_BITS-1:0] root_quota,
  input  wire tbl_rd_t              rd,
  output tbl_wr_t                   wr,
  output res_t                      res
);

  logic                 in_range;
  logic [SLOT_W-1:0]    slot;
  logic                 split_ok;
  logic [PAGE_BITS-1:0] usage_new;
  logic [KID_W-1:0]     kids_new;
  logic [PAGE_BITS-1:0] quota;

  // Child slot and split checks.
  always_comb begin
    in_range = ({1'b0, id} < (ID_W + 1)'(NUM_ENTRIES));
    slot     = SLOT_W'(id) * SLOT_W'(MAX_KIDS) + SLOT_W'(1) + SLOT_W'(rd.uc.children);
    split_ok = in_range && (cmd == CMD_SPLIT) &&
               ({1'b0, rd.uc.children} < (KID_W + 1)'(MAX_KIDS)) &&
               (slot < SLOT_W'(NUM_ENTRIES));
  end

  // New usage of the addressed entry.
  always_comb begin
    usage_new = rd.uc.usage;
    unique case (cmd)
      CMD_QUERY: usage_new = rd.uc.usage;
      CMD_SPLIT: begin
        if (split_ok) begin
          usage_new = add_sat(rd.uc.usage, amount);
        end
      end
      CMD_ALLOC: begin
        if (page != '0) begin
          usage_new = add_sat(rd.uc.usage, PAGE_BITS'(1));
        end
      end
      CMD_FREE: begin
        if (rd.uc.usage != '0) begin
          usage_new = rd.uc.usage - PAGE_BITS'(1);
        end
      end
      default: usage_new = rd.uc.usage;
    endcase
    kids_new = split_ok ? rd.uc.children + KID_W'(1) : rd.uc.children;
    quota    = (id == '0) ? root_quota : rd.qp.quota;
  end

  // Table writes: the addressed entry, and the new child on a good split.
  always_comb begin
    wr.uc_we       = in_range;
    wr.uc_addr     = id[IDX_W-1:0];
    wr.uc.usage    = usage_new;
    wr.uc.children = kids_new;
    wr.qp_we       = split_ok;
    wr.qp_addr     = slot[IDX_W-1:0];
    wr.qp.quota    = amount;
    wr.qp.parent   = id;
  end

  // Result fields.
  always_comb begin
    if (in_range) begin
      res.parent_id   = rd.qp.parent;
      res.child_count = kids_new;
      res.quota_now   = quota;
      res.usage_now   = usage_new;
      res.may_consume = (usage_new <= quota) && ((quota - usage_new) >= amount);
      res.new_child   = split_ok ? NEW_W'(slot) : NEW_W'(NUM_ENTRIES);
      res.page_out    = ((cmd == CMD_ALLOC) && (page != '0)) ? page : '0;
    end else begin
      res             = '0;
      res.new_child   = NEW_W'(NUM_ENTRIES);
    end
  end

endmodule
`default_nettype wire

// ----- src/memory_quota_container_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Memory quota container table
// Per-process page quota table with query, split, allocation and free
// commands on a streaming request channel.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is held in the request stage register, and
// its result enters the result register when the stage advances.
// Throughput: one request per cycle; the table read-modify-write is bypassed
// from one request to the next, so requests wait only while results stall.
// Reset (rst, synchronous): clears the stage and result valids, the root
// quota register and the table valid bits, so every entry reads zero.
// ----------------------------------------------------------------------------
module memory_quota_container_table import mqct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [PAGE_BITS-1:0] cfg_wdata,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata, low to high: command, proc_id, amount, alloc_page
  input  wire logic [IN_W-1:0]      s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata, low to high: parent_id, child_count, quota_now, usage_now,
  // may_consume, new_child, page_out, zero fill
  output logic [OUT_W-1:0]          m_axis_tdata
);

  logic [PAGE_BITS-1:0] root_quota;

  logic                 st_valid;
  logic [CMD_W-1:0]     st_cmd;
  logic [ID_W-1:0]      st_id;
  logic [PAGE_BITS-1:0] st_amount;
  logic [PAGE_BITS-1:0] st_page;

  logic    accept;
  logic    advance;
  tbl_rd_t rd;
  tbl_wr_t exec_wr;
  tbl_wr_t wr;
  res_t    res;

  // Handshake: the stage moves on whenever the result register is free.
  always_comb begin
    advance       = st_valid && (!m_axis_tvalid || m_axis_tready);
    s_axis_tready = !st_valid || advance;
    accept        = s_axis_tvalid && s_axis_tready;
  end

  // Root quota register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_quota <= '0;
    end else if (cfg_wen) begin
      root_quota <= cfg_wdata;
    end
  end

  // Request stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd    <= s_axis_tdata[CMD_W-1:0];
      st_id     <= s_axis_tdata[CMD_W +: ID_W];
      st_amount <= s_axis_tdata[CMD_W + ID_W +: PAGE_BITS];
      st_page   <= s_axis_tdata[CMD_W + ID_W + PAGE_BITS +: PAGE_BITS];
    end
  end

  mqct_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (s_axis_tdata[CMD_W +: IDX_W]),
    .st_addr (st_id[IDX_W-1:0]),
    .wr      (wr),
    .rd      (rd)
  );

  mqct_exec u_exec (
    .cmd        (st_cmd),
    .id         (st_id),
    .amount     (st_amount),
    .page       (st_page),
    .root_quota (root_quota),
    .rd         (rd),
    .wr         (exec_wr),
    .res        (res)
  );

  // Table writes happen only when the request moves to the result register.
  always_comb begin
    wr       = exec_wr;
    wr.uc_we = exec_wr.uc_we && advance;
    wr.qp_we = exec_wr.qp_we && advance;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= OUT_W'(res);
    end
  end

endmodule
`default_nettype wire
